// ----- sv/segment_intersection_test_core_assert.svh -----
// Assertion macros shared by the checker of the segment intersection core.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef SEGMENT_INTERSECTION_TEST_CORE_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_CORE_ASSERT_SVH

// Property checked on every rising edge, disabled while reset is asserted.
`define SIT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("segment intersection core: assertion failed");

// Expression that must never be true outside reset.
`define SIT_ASSERT_NEVER(lbl, expr) \
	`SIT_ASSERT(lbl, !(expr))

`endif

// ----- sv/sit_pkg.sv -----
// Package of the segment intersection core: default widths and pipeline depth.
// No dependencies; used by every module of the core and by its checker.
`timescale 1ns / 1ps

package sit_pkg;

	// default coordinate width (signed Q.4 fixed point)
	localparam int unsigned COORD_WIDTH_DEF = 16;

	// register stages from accepted item to strobed result
	localparam int unsigned PIPE_DEPTH = 4;

endpackage

// ----- sv/sit_diff.sv -----
// Stage 1 of the segment intersection core: edge and offset differences.
// Depends on sit_pkg for the default coordinate width.
`timescale 1ns / 1ps

module sit_diff #(
	parameter int unsigned COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [COORD_WIDTH-1:0]        ax0,
	input  logic [COORD_WIDTH-1:0]        ay0,
	input  logic [COORD_WIDTH-1:0]        ax1,
	input  logic [COORD_WIDTH-1:0]        ay1,
	input  logic [COORD_WIDTH-1:0]        bx0,
	input  logic [COORD_WIDTH-1:0]        by0,
	input  logic [COORD_WIDTH-1:0]        bx1,
	input  logic [COORD_WIDTH-1:0]        by1,
	output logic                          valid_s1,
	output logic signed [COORD_WIDTH:0]   adx_s1,
	output logic signed [COORD_WIDTH:0]   ady_s1,
	output logic signed [COORD_WIDTH:0]   bdx_s1,
	output logic signed [COORD_WIDTH:0]   bdy_s1,
	output logic signed [COORD_WIDTH:0]   sx_s1,
	output logic signed [COORD_WIDTH:0]   sy_s1
);

	localparam int unsigned DW = COORD_WIDTH + 1;

	function automatic logic signed [DW-1:0] sub_ext(
		input logic [COORD_WIDTH-1:0] p,
		input logic [COORD_WIDTH-1:0] q
	);
		logic signed [DW-1:0] pe;
		logic signed [DW-1:0] qe;
		pe = $signed({p[COORD_WIDTH-1], p});
		qe = $signed({q[COORD_WIDTH-1], q});
		return pe - qe;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset; advance every cycle
	always_ff @(posedge clk) begin
		adx_s1 <= sub_ext(ax0, ax1);
		ady_s1 <= sub_ext(ay0, ay1);
		bdx_s1 <= sub_ext(bx0, bx1);
		bdy_s1 <= sub_ext(by0, by1);
		sx_s1  <= sub_ext(ax0, bx0);
		sy_s1  <= sub_ext(ay0, by0);
	end

endmodule

// ----- sv/sit_prod.sv -----
// Stage 2 of the segment intersection core: the six cross-product terms.
// Depends on sit_pkg for the default coordinate width.
`timescale 1ns / 1ps

module sit_prod #(
	parameter int unsigned COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_s1,
	input  logic signed [COORD_WIDTH:0]       adx_s1,
	input  logic signed [COORD_WIDTH:0]       ady_s1,
	input  logic signed [COORD_WIDTH:0]       bdx_s1,
	input  logic signed [COORD_WIDTH:0]       bdy_s1,
	input  logic signed [COORD_WIDTH:0]       sx_s1,
	input  logic signed [COORD_WIDTH:0]       sy_s1,
	output logic                              valid_s2,
	output logic signed [2*COORD_WIDTH+1:0]   den_p_s2,
	output logic signed [2*COORD_WIDTH+1:0]   den_n_s2,
	output logic signed [2*COORD_WIDTH+1:0]   tn_p_s2,
	output logic signed [2*COORD_WIDTH+1:0]   tn_n_s2,
	output logic signed [2*COORD_WIDTH+1:0]   un_p_s2,
	output logic signed [2*COORD_WIDTH+1:0]   un_n_s2
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// one multiplier per term, each result registered
	always_ff @(posedge clk) begin
		den_p_s2 <= adx_s1 * bdy_s1;
		den_n_s2 <= ady_s1 * bdx_s1;
		tn_p_s2  <= sx_s1 * bdy_s1;
		tn_n_s2  <= sy_s1 * bdx_s1;
		un_p_s2  <= ady_s1 * sx_s1;
		un_n_s2  <= adx_s1 * sy_s1;
	end

endmodule

// ----- sv/sit_judge.sv -----
// Stages 3 and 4 of the segment intersection core: determinant sums, then
// the sign-corrected range test. Depends on sit_pkg for the default width.
`timescale 1ns / 1ps

module sit_judge #(
	parameter int unsigned COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_s2,
	input  logic signed [2*COORD_WIDTH+1:0]   den_p_s2,
	input  logic signed [2*COORD_WIDTH+1:0]   den_n_s2,
	input  logic signed [2*COORD_WIDTH+1:0]   tn_p_s2,
	input  logic signed [2*COORD_WIDTH+1:0]   tn_n_s2,
	input  logic signed [2*COORD_WIDTH+1:0]   un_p_s2,
	input  logic signed [2*COORD_WIDTH+1:0]   un_n_s2,
	output logic                              valid_s4,
	output logic                              hit_s4
);

	localparam int unsigned PW = 2 * COORD_WIDTH + 2;
	localparam int unsigned SW = PW + 1;

	logic                 valid_s3;
	logic signed [SW-1:0] den_s3;
	logic signed [SW-1:0] tn_s3;
	logic signed [SW-1:0] un_s3;
	logic                 den_zero;
	logic                 den_neg;
	logic                 in_pos;
	logic                 in_neg;
	logic                 hit;

	function automatic logic signed [SW-1:0] diff_ext(
		input logic signed [PW-1:0] p,
		input logic signed [PW-1:0] n
	);
		logic signed [SW-1:0] pe;
		logic signed [SW-1:0] ne;
		pe = $signed({p[PW-1], p});
		ne = $signed({n[PW-1], n});
		return pe - ne;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		den_s3 <= diff_ext(den_p_s2, den_n_s2);
		tn_s3  <= diff_ext(tn_p_s2, tn_n_s2);
		un_s3  <= diff_ext(un_p_s2, un_n_s2);
	end

	// mirror the bounds for a negative determinant rather than negate
	always_comb begin
		den_zero = (den_s3 == '0);
		den_neg  = den_s3[SW-1];
		in_pos   = (tn_s3 >= 0) && (tn_s3 <= den_s3) && (un_s3 >= 0) && (un_s3 <= den_s3);
		in_neg   = (tn_s3 <= 0) && (tn_s3 >= den_s3) && (un_s3 <= 0) && (un_s3 >= den_s3);
		hit      = !den_zero && (den_neg ? in_neg : in_pos);
	end

	always_ff @(posedge clk) begin
		hit_s4 <= hit;
	end

endmodule

// ----- sv/segment_intersection_test_core.sv -----
// Top level of the segment intersection core: four-stage exact test of two
// segments. Depends on sit_pkg, sit_diff, sit_prod and sit_judge.
`timescale 1ns / 1ps

//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------------------
//  item in  | start, busy       | a_start_x .. b_end_y (signed, Q.4 coords)
//  result   | done (strobe)     | intersects
//
// One item may be accepted in every cycle; busy is never raised. The result
// of each accepted item is strobed on done after it has passed the four
// register stages (differences, products, sums, range test) in that order.
// Reset clears only the valid bits of the stages; no result is lost or
// repeated, and the receiver cannot stall, so the pipeline always advances.
module segment_intersection_test_core #(
	parameter int unsigned COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [COORD_WIDTH-1:0] a_start_x,
	input  logic [COORD_WIDTH-1:0] a_start_y,
	input  logic [COORD_WIDTH-1:0] a_end_x,
	input  logic [COORD_WIDTH-1:0] a_end_y,
	input  logic [COORD_WIDTH-1:0] b_start_x,
	input  logic [COORD_WIDTH-1:0] b_start_y,
	input  logic [COORD_WIDTH-1:0] b_end_x,
	input  logic [COORD_WIDTH-1:0] b_end_y,
	output logic                   done,
	output logic                   intersects
);

	localparam int unsigned PW = 2 * COORD_WIDTH + 2;

	logic                       accept;
	logic                       valid_s1;
	logic signed [COORD_WIDTH:0] adx_s1;
	logic signed [COORD_WIDTH:0] ady_s1;
	logic signed [COORD_WIDTH:0] bdx_s1;
	logic signed [COORD_WIDTH:0] bdy_s1;
	logic signed [COORD_WIDTH:0] sx_s1;
	logic signed [COORD_WIDTH:0] sy_s1;
	logic                       valid_s2;
	logic signed [PW-1:0]       den_p_s2;
	logic signed [PW-1:0]       den_n_s2;
	logic signed [PW-1:0]       tn_p_s2;
	logic signed [PW-1:0]       tn_n_s2;
	logic signed [PW-1:0]       un_p_s2;
	logic signed [PW-1:0]       un_n_s2;

	// the pipeline never holds, so an item is taken whenever start is high
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// stage 1: direction vectors of both segments and the start offset
	sit_diff #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_diff (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.ax0      (a_start_x),
		.ay0      (a_start_y),
		.ax1      (a_end_x),
		.ay1      (a_end_y),
		.bx0      (b_start_x),
		.by0      (b_start_y),
		.bx1      (b_end_x),
		.by1      (b_end_y),
		.valid_s1 (valid_s1),
		.adx_s1   (adx_s1),
		.ady_s1   (ady_s1),
		.bdx_s1   (bdx_s1),
		.bdy_s1   (bdy_s1),
		.sx_s1    (sx_s1),
		.sy_s1    (sy_s1)
	);

	// stage 2: the six cross-product terms, one multiplier each
	sit_prod #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.adx_s1   (adx_s1),
		.ady_s1   (ady_s1),
		.bdx_s1   (bdx_s1),
		.bdy_s1   (bdy_s1),
		.sx_s1    (sx_s1),
		.sy_s1    (sy_s1),
		.valid_s2 (valid_s2),
		.den_p_s2 (den_p_s2),
		.den_n_s2 (den_n_s2),
		.tn_p_s2  (tn_p_s2),
		.tn_n_s2  (tn_n_s2),
		.un_p_s2  (un_p_s2),
		.un_n_s2  (un_n_s2)
	);

	// stages 3 and 4: determinant and numerators, then the inclusive
	// range test; a zero determinant (parallel, collinear or degenerate)
	// never reports a hit
	sit_judge #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_judge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.den_p_s2 (den_p_s2),
		.den_n_s2 (den_n_s2),
		.tn_p_s2  (tn_p_s2),
		.tn_n_s2  (tn_n_s2),
		.un_p_s2  (un_p_s2),
		.un_n_s2  (un_n_s2),
		.valid_s4 (done),
		.hit_s4   (intersects)
	);

endmodule

// ----- sv/sit_checker.sv -----
// Port-level checker for the segment intersection core, bound to the top.
// Depends on sit_pkg and segment_intersection_test_core_assert.svh.
`timescale 1ns / 1ps
`include "segment_intersection_test_core_assert.svh"

module sit_checker #(
	parameter int unsigned COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic [COORD_WIDTH-1:0] a_start_x,
	input logic [COORD_WIDTH-1:0] a_start_y,
	input logic [COORD_WIDTH-1:0] a_end_x,
	input logic [COORD_WIDTH-1:0] a_end_y,
	input logic [COORD_WIDTH-1:0] b_start_x,
	input logic [COORD_WIDTH-1:0] b_start_y,
	input logic [COORD_WIDTH-1:0] b_end_x,
	input logic [COORD_WIDTH-1:0] b_end_y,
	input logic                   done,
	input logic                   intersects
);

	logic accept;
	logic degen_a;
	logic degen_b;

	assign accept  = start && !busy;
	assign degen_a = (a_start_x == a_end_x) && (a_start_y == a_end_y);
	assign degen_b = (b_start_x == b_end_x) && (b_start_y == b_end_y);

	// the core never pushes back
	`SIT_ASSERT_NEVER(a_never_busy, busy)

	// every accepted item yields its result after the pipeline depth
	`SIT_ASSERT(a_done_follows, accept |-> ##(sit_pkg::PIPE_DEPTH) done)

	// no result appears without an accepted item behind it
	`SIT_ASSERT(a_no_phantom, done |-> $past(accept, sit_pkg::PIPE_DEPTH))

	// a segment shrunk to a point never intersects
	`SIT_ASSERT(a_degen_miss, (accept && (degen_a || degen_b)) |-> ##(sit_pkg::PIPE_DEPTH) !intersects)

endmodule

bind segment_intersection_test_core sit_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_sit_checker (.*);
